>>> src/latm_loas_au_framer_top_macros.svh
// assertion helpers for the loas framer
`ifndef LATM_LOAS_AU_FRAMER_TOP_MACROS_SVH
`define LATM_LOAS_AU_FRAMER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LATM_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LATM_CHECK_RESET(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) rst |=> prop) else $error(msg);
`else
`define LATM_CHECK(lbl, prop, msg)
`define LATM_CHECK_RESET(lbl, prop, msg)
`endif
`endif

>>> src/latm_pkg.sv
package latm_pkg;

  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] STEP_FIRST    = 5'd0;
  localparam logic [STEP_W-1:0] STEP_SBR      = 5'd12;
  localparam logic [STEP_W-1:0] STEP_ASC_DONE = 5'd17;
  localparam logic [STEP_W-1:0] STEP_TAIL     = 5'd22;
  localparam logic [STEP_W-1:0] STEP_IDLE     = 5'd23;

  // register indexes on the config port
  localparam logic [1:0] REG_SBR_ENABLE   = 2'd0;
  localparam logic [1:0] REG_CORE_RATE    = 2'd1;
  localparam logic [1:0] REG_CHANNEL_CFG  = 2'd2;
  localparam logic [1:0] REG_EXT_RATE     = 2'd3;

  typedef enum logic [2:0] {
    OP_IDLE = 3'd0,
    OP_PUT  = 3'd1,
    OP_RUNS = 3'd2,
    OP_JSBR = 3'd3,
    OP_JMP  = 3'd4,
    OP_END  = 3'd5,
    OP_TAIL = 3'd6
  } op_t;

  typedef enum logic [3:0] {
    SRC_CONST  = 4'd0,
    SRC_CNT_HI = 4'd1,
    SRC_CNT_LO = 4'd2,
    SRC_CORE   = 4'd3,
    SRC_CHAN   = 4'd4,
    SRC_EXT    = 4'd5,
    SRC_RUNS   = 4'd6,
    SRC_DATA   = 4'd7,
    SRC_PAD    = 4'd8
  } src_t;

  typedef struct packed {
    op_t               op;
    src_t              src;
    logic [3:0]        width;
    logic [7:0]        value;
    logic [STEP_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic       start;
    logic       put;
    logic       pay;
    logic       arm;
    logic       dec_runs;
    logic       last;
    src_t       src;
    logic [3:0] width;
    logic [7:0] value;
  } dp_ctrl_t;

  typedef struct packed {
    logic sbr;
    logic runs_zero;
    logic len_zero;
    logic res_zero;
    logic final_byte;
    logic active;
    logic space;
  } dp_stat_t;

  typedef struct packed {
    logic       sbr_enable;
    logic [3:0] core_rate_index;
    logic [3:0] channel_config;
    logic [3:0] extension_rate_index;
  } cfg_t;

  function automatic ucw_t uc_put(input src_t src, input logic [3:0] width,
                                  input logic [7:0] value);
    ucw_t w;
    w = '{op: OP_PUT, src: src, width: width, value: value, target: '0};
    return w;
  endfunction

  function automatic ucw_t uc_ctl(input op_t op, input logic [STEP_W-1:0] target);
    ucw_t w;
    w = '{op: op, src: SRC_CONST, width: 4'd8, value: 8'h00, target: target};
    return w;
  endfunction

  // header program: sync, frame count, stream mux config, audio config,
  // frame length fields, then the runs of 255 and the remainder
  function automatic ucw_t ucode(input logic [STEP_W-1:0] pc);
    ucw_t w;
    case (pc)
      5'd0:  w = uc_put(SRC_CONST, 4'd8, 8'h56);
      5'd1:  w = uc_put(SRC_CONST, 4'd3, 8'h07);
      5'd2:  w = uc_put(SRC_CNT_HI, 4'd8, 8'h00);
      5'd3:  w = uc_put(SRC_CNT_LO, 4'd5, 8'h00);
      5'd4:  w = uc_put(SRC_CONST, 4'd8, 8'h20);
      5'd5:  w = uc_put(SRC_CONST, 4'd8, 8'h00);
      5'd6:  w = uc_ctl(OP_JSBR, STEP_SBR);
      5'd7:  w = uc_put(SRC_CONST, 4'd5, 8'h02);
      5'd8:  w = uc_put(SRC_CORE, 4'd4, 8'h00);
      5'd9:  w = uc_put(SRC_CHAN, 4'd4, 8'h00);
      5'd10: w = uc_put(SRC_CONST, 4'd3, 8'h04);
      5'd11: w = uc_ctl(OP_JMP, STEP_ASC_DONE);
      5'd12: w = uc_put(SRC_CONST, 4'd5, 8'h05);
      5'd13: w = uc_put(SRC_CORE, 4'd4, 8'h00);
      5'd14: w = uc_put(SRC_CHAN, 4'd4, 8'h00);
      5'd15: w = uc_put(SRC_EXT, 4'd4, 8'h00);
      5'd16: w = uc_put(SRC_CONST, 4'd8, 8'h14);
      5'd17: w = uc_put(SRC_CONST, 4'd3, 8'h00);
      5'd18: w = uc_put(SRC_CONST, 4'd8, 8'hFF);
      5'd19: w = uc_put(SRC_CONST, 4'd2, 8'h00);
      5'd20: begin
        w = uc_ctl(OP_RUNS, '0);
        w.src = SRC_RUNS;
      end
      5'd21: w = uc_ctl(OP_END, '0);
      5'd22: begin
        w = uc_ctl(OP_TAIL, '0);
        w.src = SRC_PAD;
      end
      default: w = uc_ctl(OP_IDLE, '0);
    endcase
    return w;
  endfunction

endpackage

>>> src/latm_seq.sv
`include "latm_loas_au_framer_top_macros.svh"

module latm_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_ready,
  input  latm_pkg::dp_stat_t  stat,
  output latm_pkg::dp_ctrl_t  ctrl
);

  logic [latm_pkg::STEP_W-1:0] pc;
  logic [latm_pkg::STEP_W-1:0] pc_next;
  latm_pkg::ucw_t              word;
  logic                        accept;

  always_comb begin
    word       = latm_pkg::ucode(pc);
    ctrl       = '0;
    ctrl.src   = word.src;
    ctrl.width = word.width;
    ctrl.value = word.value;
    pc_next    = pc;
    in_ready   = (word.op == latm_pkg::OP_IDLE) && stat.space;
    accept     = in_valid && in_ready;
    case (word.op)
      latm_pkg::OP_IDLE: begin
        if (accept) begin
          if (!in_kind) begin
            ctrl.start = 1'b1;
            pc_next    = latm_pkg::STEP_FIRST;
          end else if (stat.active) begin
            ctrl.put   = 1'b1;
            ctrl.pay   = 1'b1;
            ctrl.src   = latm_pkg::SRC_DATA;
            ctrl.width = 4'd8;
            if (stat.final_byte) begin
              // leftover bits need a padded byte of their own
              if (stat.res_zero) begin
                ctrl.last = 1'b1;
              end else begin
                pc_next = latm_pkg::STEP_TAIL;
              end
            end
          end
        end
      end
      latm_pkg::OP_PUT: begin
        if (stat.space) begin
          ctrl.put = 1'b1;
          pc_next  = latm_pkg::STEP_W'(pc + 5'd1);
        end
      end
      latm_pkg::OP_RUNS: begin
        if (stat.space) begin
          ctrl.put = 1'b1;
          if (stat.runs_zero) begin
            pc_next = latm_pkg::STEP_W'(pc + 5'd1);
          end else begin
            ctrl.dec_runs = 1'b1;
          end
        end
      end
      latm_pkg::OP_JSBR: begin
        pc_next = stat.sbr ? word.target : latm_pkg::STEP_W'(pc + 5'd1);
      end
      latm_pkg::OP_JMP: begin
        pc_next = word.target;
      end
      latm_pkg::OP_END: begin
        ctrl.arm = 1'b1;
        pc_next  = (stat.len_zero && !stat.res_zero) ? latm_pkg::STEP_TAIL
                                                     : latm_pkg::STEP_IDLE;
      end
      latm_pkg::OP_TAIL: begin
        if (stat.space) begin
          ctrl.put  = 1'b1;
          ctrl.last = 1'b1;
          pc_next   = latm_pkg::STEP_IDLE;
        end
      end
      default: begin
        pc_next = latm_pkg::STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= latm_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  `LATM_CHECK(a_pc_range, pc <= latm_pkg::STEP_IDLE, "step counter out of program")
  `LATM_CHECK(a_tail_has_bits, (word.op == latm_pkg::OP_TAIL) |-> !stat.res_zero, "pad step without leftover bits")
  `LATM_CHECK(a_pay_active, ctrl.pay |-> (stat.active && in_kind), "payload taken outside a frame")
  `LATM_CHECK_RESET(a_reset_idle, pc == latm_pkg::STEP_IDLE, "sequencer not idle after reset")

endmodule

>>> src/latm_dp.sv
`include "latm_loas_au_framer_top_macros.svh"

module latm_dp #(
  parameter int MAX_AU_BYTES = 4095
) (
  input  logic                clk,
  input  logic                rst,
  input  latm_pkg::cfg_t      cfg,
  input  latm_pkg::dp_ctrl_t  ctrl,
  output latm_pkg::dp_stat_t  stat,
  input  logic [11:0]         au_length,
  input  logic [7:0]          data_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);

  logic [6:0]  acc;
  logic [2:0]  cnt;
  logic [11:0] len_r;
  logic [4:0]  runs_left;
  logic [7:0]  rem_r;
  logic [11:0] remaining;
  logic        active;

  logic [11:0] len_sat;
  logic [12:0] len_p1;
  logic [12:0] quot;
  logic [4:0]  runs;
  logic [7:0]  rem;
  logic [12:0] frame_count;
  logic [7:0]  src_val;
  logic [3:0]  wd;
  logic [7:0]  masked;
  logic [14:0] comb_bits;
  logic [3:0]  sum;
  logic [2:0]  sh;
  logic [7:0]  emit;
  logic [6:0]  rest;
  logic        full;
  logic        space;

  always_comb begin
    len_sat = au_length;
    if ({1'b0, au_length} > 13'(MAX_AU_BYTES)) begin
      len_sat = 12'(MAX_AU_BYTES);
    end
    // divide by 255 without a divider
    len_p1 = {1'b0, len_sat} + 13'd1;
    quot   = (len_p1 + (len_p1 >> 8)) >> 8;
    runs   = quot[4:0];
    rem    = 8'({1'b0, len_sat} - ({8'd0, runs} << 8) + {8'd0, runs});
  end

  assign frame_count = {1'b0, len_r} + {8'd0, runs_left}
                     + (cfg.sbr_enable ? 13'd8 : 13'd7);

  always_comb begin
    case (ctrl.src)
      latm_pkg::SRC_CONST:  src_val = ctrl.value;
      latm_pkg::SRC_CNT_HI: src_val = frame_count[12:5];
      latm_pkg::SRC_CNT_LO: src_val = {3'd0, frame_count[4:0]};
      latm_pkg::SRC_CORE:   src_val = {4'd0, cfg.core_rate_index};
      latm_pkg::SRC_CHAN:   src_val = {4'd0, cfg.channel_config};
      latm_pkg::SRC_EXT:    src_val = {4'd0, cfg.extension_rate_index};
      latm_pkg::SRC_RUNS:   src_val = (runs_left == 5'd0) ? rem_r : 8'hFF;
      latm_pkg::SRC_DATA:   src_val = data_byte;
      default:              src_val = 8'h00;
    endcase
    wd = (ctrl.src == latm_pkg::SRC_PAD) ? (4'd8 - {1'b0, cnt}) : ctrl.width;
  end

  // bit packer: append wd bits, split off a whole byte once eight are held
  always_comb begin
    masked    = src_val & 8'((9'd1 << wd) - 9'd1);
    comb_bits = ({8'd0, acc} << wd) | {7'd0, masked};
    sum       = {1'b0, cnt} + wd;
    full      = sum[3];
    sh        = sum[2:0];
    emit      = 8'(comb_bits >> sh);
    rest      = 7'(comb_bits & ((15'd1 << sh) - 15'd1));
  end

  assign space = !out_valid || out_ready;

  always_comb begin
    stat.sbr        = cfg.sbr_enable;
    stat.runs_zero  = (runs_left == 5'd0);
    stat.len_zero   = (len_r == 12'd0);
    stat.res_zero   = (cnt == 3'd0);
    stat.final_byte = (remaining <= 12'd1);
    stat.active     = active;
    stat.space      = space;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      active    <= 1'b0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.start) begin
        acc       <= '0;
        cnt       <= '0;
        active    <= 1'b0;
        remaining <= '0;
      end else if (ctrl.put) begin
        acc <= full ? rest : comb_bits[6:0];
        cnt <= sh;
      end
      if (ctrl.arm) begin
        active    <= (len_r != 12'd0);
        remaining <= len_r;
      end
      if (ctrl.pay) begin
        if (remaining <= 12'd1) begin
          active    <= 1'b0;
          remaining <= '0;
        end else begin
          remaining <= remaining - 12'd1;
        end
      end
      if (ctrl.put && full) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      len_r     <= len_sat;
      runs_left <= runs;
      rem_r     <= rem;
    end else if (ctrl.dec_runs) begin
      runs_left <= runs_left - 5'd1;
    end
    if (ctrl.put && full) begin
      out_byte <= emit;
      out_last <= ctrl.last;
    end
  end

  `LATM_CHECK(a_acc_clean, (acc >> cnt) == 7'd0, "stray bits above the held count")
  `LATM_CHECK(a_put_space, ctrl.put |-> space, "byte produced into a full output register")
  `LATM_CHECK(a_active_count, active |-> (remaining != 12'd0), "frame open with no bytes due")
  `LATM_CHECK_RESET(a_reset_out, !out_valid && !active, "output or frame live after reset")

endmodule

>>> src/latm_loas_au_framer_top.sv
// channel   dir  handshake                 payload
// s_axis    in   s_tvalid / s_tready       s_tuser kind, s_tdata au_length, data_byte
// m_axis    out  m_tvalid / m_tready       m_tdata out_byte, m_tlast last
// apb       in   psel, penable, pwrite     paddr, pwdata, prdata, pready (always high)
//
// a start item holds the input while the microcode header program runs, one step
// per cycle while the output has space, and through the padded byte of an empty unit
// payload items pass at one per cycle while the output has space; the last one
// is followed by a padded tail byte when header bits are left over
// rst is synchronous: config returns to defaults and no frame is open
// a stalled m_tready holds the output register and halts the next put step

module latm_loas_au_framer_top #(
  parameter int MAX_AU_BYTES = 4095
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [11:0] au_length, [19:12] data_byte, rest zero
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  latm_pkg::cfg_t     cfg;
  latm_pkg::dp_ctrl_t ctrl;
  latm_pkg::dp_stat_t stat;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sbr_enable           <= 1'b0;
      cfg.core_rate_index      <= 4'd5;
      cfg.channel_config       <= 4'd1;
      cfg.extension_rate_index <= 4'd5;
    end else if (wr_en) begin
      case (paddr[3:2])
        latm_pkg::REG_SBR_ENABLE:  cfg.sbr_enable           <= pwdata[0];
        latm_pkg::REG_CORE_RATE:   cfg.core_rate_index      <= pwdata[3:0];
        latm_pkg::REG_CHANNEL_CFG: cfg.channel_config       <= pwdata[3:0];
        latm_pkg::REG_EXT_RATE:    cfg.extension_rate_index <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      latm_pkg::REG_SBR_ENABLE:  prdata = {31'd0, cfg.sbr_enable};
      latm_pkg::REG_CORE_RATE:   prdata = {28'd0, cfg.core_rate_index};
      latm_pkg::REG_CHANNEL_CFG: prdata = {28'd0, cfg.channel_config};
      latm_pkg::REG_EXT_RATE:    prdata = {28'd0, cfg.extension_rate_index};
      default:                   prdata = 32'd0;
    endcase
  end

  latm_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  latm_dp #(
    .MAX_AU_BYTES (MAX_AU_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .stat      (stat),
    .au_length (s_tdata[11:0]),
    .data_byte (s_tdata[19:12]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

>>> verif/latm_loas_au_framer_top_test.sv
`timescale 1ns / 100ps

module latm_loas_au_framer_top_test;

  localparam int unsigned MAX_AU = 4095;
  localparam int SETTLE_CYCLES = 48;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_QUOTA = 43;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  localparam int unsigned SYNC_WORD  = 'h2B7;
  localparam int unsigned AOT_SBR    = 'h05;
  localparam int unsigned AOT_LC     = 'h02;
  localparam int unsigned GA_TAIL    = 'h4;
  localparam int unsigned FULLNESS   = 'hFF;
  localparam int unsigned RUN_LEN    = 255;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } stream_byte_t;

  typedef enum logic [1:0] {
    CHK_MODEL       = 2'd0,
    CHK_EMPTY_FRAME = 2'd1,
    CHK_NONE        = 2'd2
  } check_t;

  typedef struct packed {
    logic       kind;
    logic [11:0] au_length;
    logic [7:0] data_byte;
    check_t     chk;
  } stim_row_t;

  // empty unit right after reset: lc config, rate 5, mono
  localparam logic [7:0] DEFAULT_EMPTY_FRAME [10] = '{
    8'h56, 8'hE0, 8'h07, 8'h20, 8'h00, 8'h12, 8'h8C, 8'h1F, 8'hE0, 8'h00
  };

  localparam stim_row_t DIR_ROWS [22] = '{
    '{KIND_START, 12'd0,    8'h00, CHK_EMPTY_FRAME},
    '{KIND_BYTE,  12'd0,    8'hA5, CHK_NONE},
    '{KIND_START, 12'd1,    8'h00, CHK_MODEL},
    '{KIND_BYTE,  12'd0,    8'hFF, CHK_MODEL},
    '{KIND_START, 12'd2,    8'h00, CHK_MODEL},
    '{KIND_BYTE,  12'd0,    8'h00, CHK_MODEL},
    '{KIND_BYTE,  12'd0,    8'h80, CHK_MODEL},
    '{KIND_START, 12'd4095, 8'h00, CHK_MODEL},
    '{KIND_BYTE,  12'd0,    8'h01, CHK_MODEL},
    '{KIND_BYTE,  12'd0,    8'h7F, CHK_MODEL},
    '{KIND_START, 12'd255,  8'h00, CHK_MODEL},
    '{KIND_BYTE,  12'd0,    8'hC3, CHK_MODEL},
    '{KIND_START, 12'd254,  8'h00, CHK_MODEL},
    '{KIND_BYTE,  12'd0,    8'h3C, CHK_MODEL},
    '{KIND_START, 12'd510,  8'h00, CHK_MODEL},
    '{KIND_START, 12'd3,    8'h00, CHK_MODEL},
    '{KIND_BYTE,  12'd0,    8'h5A, CHK_MODEL},
    '{KIND_BYTE,  12'd0,    8'hA5, CHK_MODEL},
    '{KIND_BYTE,  12'd0,    8'hFF, CHK_MODEL},
    '{KIND_BYTE,  12'd0,    8'h12, CHK_NONE},
    '{KIND_START, 12'd4,    8'h00, CHK_MODEL},
    '{KIND_BYTE,  12'd0,    8'h99, CHK_MODEL}
  };

  // settings for the random phases, extremes first
  localparam latm_pkg::cfg_t PHASE_CFG [4] = '{
    '{1'b1, 4'd15, 4'd15, 4'd15},
    '{1'b0, 4'd0,  4'd0,  4'd0},
    '{1'b1, 4'd0,  4'd2,  4'd0},
    '{1'b0, 4'd15, 4'd2,  4'd15}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [11:0] au_length, [19:12] data_byte, rest zero
  logic        s_tuser = 1'b0; // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] out_byte
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  latm_loas_au_framer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // framer state as the testbench sees it
  latm_pkg::cfg_t cfg_shadow;
  logic [6:0]   left_bits;
  logic [2:0]   left_cnt;
  logic [11:0]  au_left;
  logic         in_frame;
  logic [7:0]   acc_byte;
  int unsigned  acc_fill;
  stream_byte_t fresh_bytes[$];
  stream_byte_t frame_bytes_due[$];

  int unsigned  items_taken;
  int unsigned  errors;
  logic         tx_calm;
  logic         tx_rush;
  logic         rx_calm;
  logic         long_hold_req;

  task automatic pack_bits(input int unsigned v, input int w);
    int i;
    for (i = w - 1; i >= 0; i--) begin
      acc_byte = {acc_byte[6:0], v[i]};
      acc_fill++;
      if (acc_fill == 8) begin
        fresh_bytes.push_back('{out_byte: acc_byte, last: 1'b0});
        acc_byte = '0;
        acc_fill = 0;
      end
    end
  endtask

  task automatic frame_item(input logic kind, input logic [11:0] len_in, input logic [7:0] b);
    int unsigned len, runs, head, total, c, val, i;
    logic closing;
    fresh_bytes.delete();
    if (kind == KIND_START) begin
      len = len_in;
      if (len > MAX_AU) len = MAX_AU;
      runs = len / RUN_LEN;
      head = 24 + 16 + (cfg_shadow.sbr_enable ? 25 : 16) + 13 + 8 * (runs + 1);
      total = (head + 8 * len + 7) / 8;
      acc_byte = '0;
      acc_fill = 0;
      pack_bits(SYNC_WORD, 11);
      pack_bits((total - 3) & 'h1FFF, 13);
      // mux version bits, same time framing, one subframe, program and layer
      pack_bits(0, 1);
      pack_bits(0, 1);
      pack_bits(1, 1);
      pack_bits(0, 6);
      pack_bits(0, 4);
      pack_bits(0, 3);
      if (cfg_shadow.sbr_enable) begin
        pack_bits(AOT_SBR, 5);
        pack_bits(cfg_shadow.core_rate_index, 4);
        pack_bits(cfg_shadow.channel_config, 4);
        pack_bits(cfg_shadow.extension_rate_index, 4);
        pack_bits(AOT_LC, 5);
        pack_bits(GA_TAIL, 3);
      end else begin
        pack_bits(AOT_LC, 5);
        pack_bits(cfg_shadow.core_rate_index, 4);
        pack_bits(cfg_shadow.channel_config, 4);
        pack_bits(GA_TAIL, 3);
      end
      pack_bits(0, 3);
      pack_bits(FULLNESS, 8);
      pack_bits(0, 1);
      pack_bits(0, 1);
      for (i = 0; i < runs; i++) pack_bits('hFF, 8);
      pack_bits(len % RUN_LEN, 8);
      left_bits = acc_byte[6:0];
      left_cnt = 3'(acc_fill);
      if (len == 0) begin
        if (left_cnt > 0) begin
          val = (left_bits << (8 - left_cnt)) & 'hFF;
          fresh_bytes.push_back('{out_byte: val[7:0], last: 1'b1});
        end else if (fresh_bytes.size() > 0) begin
          fresh_bytes[fresh_bytes.size() - 1].last = 1'b1;
        end
        in_frame = 1'b0;
        au_left = '0;
      end else begin
        in_frame = 1'b1;
        au_left = 12'(len);
      end
    end else if (in_frame) begin
      // leftover header bits go first, payload bits follow shifted down
      c = left_cnt;
      val = ((left_bits << (8 - c)) | (b >> c)) & 'hFF;
      closing = (au_left <= 1);
      left_bits = 7'(b & ((1 << c) - 1));
      au_left = au_left - 12'd1;
      if (closing) begin
        if (c > 0) begin
          fresh_bytes.push_back('{out_byte: val[7:0], last: 1'b0});
          val = (left_bits << (8 - c)) & 'hFF;
          fresh_bytes.push_back('{out_byte: val[7:0], last: 1'b1});
        end else begin
          fresh_bytes.push_back('{out_byte: val[7:0], last: 1'b1});
        end
        in_frame = 1'b0;
        au_left = '0;
      end else begin
        fresh_bytes.push_back('{out_byte: val[7:0], last: 1'b0});
      end
    end
  endtask

  task automatic send_item(input logic kind, input logic [11:0] len, input logic [7:0] b,
                           input check_t chk);
    int unsigned gap;
    int i;
    logic counts;
    if (tx_rush || tx_calm) gap = 0;
    else gap = $urandom_range(0, 12);
    if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {4'b0, b, len};
    do @(posedge clk); while (s_tready !== 1'b1);
    counts = (kind == KIND_START) || in_frame;
    frame_item(kind, len, b);
    case (chk)
      CHK_MODEL: begin
        foreach (fresh_bytes[i]) frame_bytes_due.push_back(fresh_bytes[i]);
      end
      CHK_EMPTY_FRAME: begin
        for (i = 0; i < 10; i++)
          frame_bytes_due.push_back('{out_byte: DEFAULT_EMPTY_FRAME[i], last: (i == 9)});
      end
      default: ;
    endcase
    if (counts) items_taken++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      latm_pkg::REG_SBR_ENABLE:  cfg_shadow.sbr_enable = val[0];
      latm_pkg::REG_CORE_RATE:   cfg_shadow.core_rate_index = val[3:0];
      latm_pkg::REG_CHANNEL_CFG: cfg_shadow.channel_config = val[3:0];
      latm_pkg::REG_EXT_RATE:    cfg_shadow.extension_rate_index = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_cfg(input latm_pkg::cfg_t c);
    reg_write(latm_pkg::REG_SBR_ENABLE, {31'b0, c.sbr_enable});
    reg_write(latm_pkg::REG_CORE_RATE, {28'b0, c.core_rate_index});
    reg_write(latm_pkg::REG_CHANNEL_CFG, {28'b0, c.channel_config});
    reg_write(latm_pkg::REG_EXT_RATE, {28'b0, c.extension_rate_index});
  endtask

  task automatic wait_drained();
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned stop_at, len, n, i, pick;
    stop_at = items_taken + quota;
    while (items_taken < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // stray byte, often outside any frame
        send_item(KIND_BYTE, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
                  CHK_MODEL);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) len = 0;
        else if (pick < 70) len = $urandom_range(1, 12);
        else if (pick < 85) len = $urandom_range(13, 64);
        else if (pick < 95) len = $urandom_range(65, 600);
        else len = $urandom_range(3000, 4095);
        n = len;
        // long units are cut short by the next start
        if (len > 64) n = $urandom_range(1, 24);
        else if (len > 0 && $urandom_range(0, 9) == 0) n = $urandom_range(0, len - 1);
        send_item(KIND_START, 12'(len), 8'($urandom_range(0, 255)), CHK_MODEL);
        for (i = 0; i < n; i++)
          send_item(KIND_BYTE, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
                    CHK_MODEL);
      end
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    int i, phase;
    latm_pkg::cfg_t c;
    cfg_shadow = '{1'b0, 4'd5, 4'd1, 4'd5};
    left_bits = '0;
    left_cnt = '0;
    au_left = '0;
    in_frame = 1'b0;
    acc_byte = '0;
    acc_fill = 0;
    items_taken = 0;
    errors = 0;
    tx_calm = 1'b0;
    tx_rush = 1'b0;
    rx_calm = 1'b0;
    long_hold_req = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i])
      send_item(DIR_ROWS[i].kind, DIR_ROWS[i].au_length, DIR_ROWS[i].data_byte,
                DIR_ROWS[i].chk);
    s_tvalid <= 1'b0;

    // the last directed unit is still open: the new settings must not touch it
    for (phase = 0; phase < 6; phase++) begin
      wait_drained();
      if (phase < 4) c = PHASE_CFG[phase];
      else c = latm_pkg::cfg_t'(13'($urandom));
      apply_cfg(c);
      if (phase == 1) begin
        // receiver holds off while a full unit is pushed back to back
        tx_rush = 1'b1;
        long_hold_req = 1'b1;
        send_item(KIND_START, 12'd60, 8'h00, CHK_MODEL);
        for (i = 0; i < 60; i++)
          send_item(KIND_BYTE, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
                    CHK_MODEL);
        tx_rush = 1'b0;
      end
      random_phase(PHASE_QUOTA);
    end

    wait_drained();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin : out_side
    int unsigned stall;
    stream_byte_t want;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        stall = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end else if (rx_calm) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 12);
      end
      if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      if (frame_bytes_due.size() == 0) begin
        $error("unexpected item: out_byte %h last %b", m_tdata, m_tlast);
        errors++;
      end else begin
        want = frame_bytes_due.pop_front();
        if (m_tdata !== want.out_byte) begin
          $error("out_byte: expected %h actual %h", want.out_byte, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %b actual %b", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
